// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define MTT_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: assertion failed");

// Condition must never be seen at a rising edge outside reset.
`define MTT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("%m: forbidden condition seen");

`endif

// ===== src/mtt_pkg.sv =====
package mtt_pkg;

	// Default sizes
	localparam int unsigned NUM_TIMERS_DEF = 16;
	localparam int unsigned COUNT_BITS_DEF = 16;

	// Fixed field widths and result limit per tick
	localparam int unsigned PERIOD_W    = 16;
	localparam int unsigned TAG_W       = 32;
	localparam int unsigned MAX_RESULTS = 16;
	localparam int unsigned FIRED_N_W   = $clog2(MAX_RESULTS + 1);

	typedef enum logic [0:0] {
		REQ_TICK = 1'b0,
		REQ_ADD  = 1'b1
	} req_kind_t;

	typedef enum logic [1:0] {
		KIND_ACCEPTED = 2'd0,
		KIND_REJECTED = 2'd1,
		KIND_FIRED    = 2'd2
	} result_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} ctrl_state_t;

	typedef struct packed {
		req_kind_t             req_type;
		logic [PERIOD_W-1:0]   period;
		logic                  periodic;
		logic [TAG_W-1:0]      tag;
	} req_t;

	typedef struct packed {
		result_kind_t          result_kind;
		logic [TAG_W-1:0]      fired_tag;
		logic                  was_removed;
		logic                  last_of_run;
	} rsp_t;

endpackage

// ===== src/mtt_mem.sv =====
module mtt_mem #(
	parameter int unsigned DEPTH  = mtt_pkg::NUM_TIMERS_DEF,
	parameter int unsigned DATA_W = mtt_pkg::PERIOD_W + mtt_pkg::COUNT_BITS_DEF + 1
		+ mtt_pkg::TAG_W,
	localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	// One write port, one registered read port; read data holds without rd_en
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== src/mtt_ctrl.sv =====
module mtt_ctrl #(
	parameter int unsigned NUM_TIMERS = mtt_pkg::NUM_TIMERS_DEF,
	parameter int unsigned COUNT_BITS = mtt_pkg::COUNT_BITS_DEF,
	localparam int unsigned IDX_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1,
	localparam int unsigned DATA_W = mtt_pkg::PERIOD_W + COUNT_BITS + 1 + mtt_pkg::TAG_W
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  mtt_pkg::req_t       req_data,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output mtt_pkg::rsp_t       rsp_data,
	output logic                mem_wr_en,
	output logic [IDX_W-1:0]    mem_wr_addr,
	output logic [DATA_W-1:0]   mem_wr_data,
	output logic                mem_rd_en,
	output logic [IDX_W-1:0]    mem_rd_addr,
	input  logic [DATA_W-1:0]   mem_rd_data
);

	import mtt_pkg::*;

	localparam int unsigned OCC_W = $clog2(NUM_TIMERS + 1);
	localparam int unsigned CMP_W = (COUNT_BITS > PERIOD_W) ? COUNT_BITS : PERIOD_W;

	ctrl_state_t            state_q, state_d;
	logic [OCC_W-1:0]       occ_q, occ_d;
	logic [OCC_W-1:0]       rd_q, rd_d;
	logic [OCC_W-1:0]       wr_q, wr_d;
	logic                   rd_valid_s1, rd_valid_d;
	logic [FIRED_N_W-1:0]   fired_n_q, fired_n_d;
	logic                   pend_valid_q, pend_valid_d;
	logic [TAG_W-1:0]       pend_tag_q, pend_tag_d;
	logic                   pend_removed_q, pend_removed_d;
	logic                   rsp_valid_q, rsp_valid_d;
	rsp_t                   rsp_data_q, rsp_data_d;

	// Fields of the most recently read entry
	logic [PERIOD_W-1:0]    e_period;
	logic [COUNT_BITS-1:0]  e_count;
	logic                   e_periodic;
	logic [TAG_W-1:0]       e_tag;
	logic [COUNT_BITS-1:0]  cnt_inc;
	logic [COUNT_BITS-1:0]  cnt_next;

	logic out_free;
	logic accept;
	logic full;
	logic fire;
	logic drop;
	logic report;
	logic blocked;
	logic more;

	assign e_tag      = mem_rd_data[TAG_W-1:0];
	assign e_periodic = mem_rd_data[TAG_W];
	assign e_count    = mem_rd_data[TAG_W+1 +: COUNT_BITS];
	assign e_period   = mem_rd_data[TAG_W+1+COUNT_BITS +: PERIOD_W];

	// Per-entry update: count, expiry, removal
	assign cnt_inc  = e_count + COUNT_BITS'(1);
	assign fire     = (e_period != '0) && (CMP_W'(cnt_inc) == CMP_W'(e_period));
	assign drop     = fire && !e_periodic;
	assign report   = fire && (fired_n_q < FIRED_N_W'(MAX_RESULTS));
	assign cnt_next = fire ? '0 : cnt_inc;

	// Handshake
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign accept    = req_valid && (state_q == ST_IDLE) && out_free;
	assign req_stall = !((state_q == ST_IDLE) && out_free);
	assign full      = (occ_q == OCC_W'(NUM_TIMERS));
	assign blocked   = report && pend_valid_q && !out_free;
	assign more      = (rd_q < occ_q);

	// Sequencer: next state, memory port, result staging
	always_comb begin
		state_d        = state_q;
		occ_d          = occ_q;
		rd_d           = rd_q;
		wr_d           = wr_q;
		rd_valid_d     = rd_valid_s1;
		fired_n_d      = fired_n_q;
		pend_valid_d   = pend_valid_q;
		pend_tag_d     = pend_tag_q;
		pend_removed_d = pend_removed_q;
		rsp_valid_d    = rsp_valid_q && rsp_stall;
		rsp_data_d     = rsp_data_q;
		mem_wr_en      = 1'b0;
		mem_wr_addr    = wr_q[IDX_W-1:0];
		mem_wr_data    = {e_period, cnt_next, e_periodic, e_tag};
		mem_rd_en      = 1'b0;
		mem_rd_addr    = rd_q[IDX_W-1:0];

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req_data.req_type == REQ_ADD) begin
						rsp_valid_d             = 1'b1;
						rsp_data_d.result_kind  = full ? KIND_REJECTED : KIND_ACCEPTED;
						rsp_data_d.fired_tag    = '0;
						rsp_data_d.was_removed  = 1'b0;
						rsp_data_d.last_of_run  = 1'b1;
						if (!full) begin
							mem_wr_en   = 1'b1;
							mem_wr_addr = occ_q[IDX_W-1:0];
							mem_wr_data = {req_data.period, {COUNT_BITS{1'b0}},
								req_data.periodic, req_data.tag};
							occ_d       = occ_q + OCC_W'(1);
						end
					end else if (occ_q != '0) begin
						mem_rd_en    = 1'b1;
						mem_rd_addr  = '0;
						rd_d         = OCC_W'(1);
						wr_d         = '0;
						rd_valid_d   = 1'b1;
						fired_n_d    = '0;
						pend_valid_d = 1'b0;
						state_d      = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (!rd_valid_s1) begin
					// All entries visited: compacted length becomes occupancy
					occ_d   = wr_q;
					state_d = pend_valid_q ? ST_FLUSH : ST_IDLE;
				end else if (!blocked) begin
					if (!drop) begin
						mem_wr_en = 1'b1;
						wr_d      = wr_q + OCC_W'(1);
					end
					if (report) begin
						// Previous firing is known not to be the last one
						if (pend_valid_q) begin
							rsp_valid_d            = 1'b1;
							rsp_data_d.result_kind = KIND_FIRED;
							rsp_data_d.fired_tag   = pend_tag_q;
							rsp_data_d.was_removed = pend_removed_q;
							rsp_data_d.last_of_run = 1'b0;
						end
						pend_valid_d   = 1'b1;
						pend_tag_d     = e_tag;
						pend_removed_d = drop;
						fired_n_d      = fired_n_q + FIRED_N_W'(1);
					end
					if (more) begin
						mem_rd_en = 1'b1;
						rd_d      = rd_q + OCC_W'(1);
					end else begin
						rd_valid_d = 1'b0;
					end
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					rsp_valid_d            = 1'b1;
					rsp_data_d.result_kind = KIND_FIRED;
					rsp_data_d.fired_tag   = pend_tag_q;
					rsp_data_d.was_removed = pend_removed_q;
					rsp_data_d.last_of_run = 1'b1;
					pend_valid_d           = 1'b0;
					state_d                = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			occ_q        <= '0;
			rd_q         <= '0;
			wr_q         <= '0;
			rd_valid_s1  <= 1'b0;
			fired_n_q    <= '0;
			pend_valid_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			occ_q        <= occ_d;
			rd_q         <= rd_d;
			wr_q         <= wr_d;
			rd_valid_s1  <= rd_valid_d;
			fired_n_q    <= fired_n_d;
			pend_valid_q <= pend_valid_d;
			rsp_valid_q  <= rsp_valid_d;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		pend_tag_q     <= pend_tag_d;
		pend_removed_q <= pend_removed_d;
		rsp_data_q     <= rsp_data_d;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_data_q;

endmodule

// ===== src/multi_software_timer_table.sv =====
// Add: one transfer in, its result is offered the next cycle; ready again unless it stalls.
// Tick: one entry per cycle from the timer memory unless a firing waits on a stalled output;
// the last firing is released after the scan; an empty table gives no result.
// Fired results keep entry order; each but the last is offered when the next firing is seen.
// Reset clears occupancy (table empty); memory contents are not cleared.
module multi_software_timer_table #(
	parameter int unsigned NUM_TIMERS = mtt_pkg::NUM_TIMERS_DEF,
	parameter int unsigned COUNT_BITS = mtt_pkg::COUNT_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  mtt_pkg::req_t  req_data,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output mtt_pkg::rsp_t  rsp_data
);

	import mtt_pkg::*;

	localparam int unsigned IDX_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int unsigned DATA_W = PERIOD_W + COUNT_BITS + 1 + TAG_W;

	logic              mem_wr_en;
	logic [IDX_W-1:0]  mem_wr_addr;
	logic [DATA_W-1:0] mem_wr_data;
	logic              mem_rd_en;
	logic [IDX_W-1:0]  mem_rd_addr;
	logic [DATA_W-1:0] mem_rd_data;

	// Sequencer and result staging
	mtt_ctrl #(
		.NUM_TIMERS (NUM_TIMERS),
		.COUNT_BITS (COUNT_BITS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req_data    (req_data),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp_data    (rsp_data),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data),
		.mem_rd_en   (mem_rd_en),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data)
	);

	// Timer entry storage
	mtt_mem #(
		.DEPTH  (NUM_TIMERS),
		.DATA_W (DATA_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

endmodule

// ===== src/mtt_chk.sv =====
`include "assert_macros.svh"

module mtt_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input mtt_pkg::req_t req_data,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input mtt_pkg::rsp_t rsp_data
);

	import mtt_pkg::*;

	logic add_xfer;
	logic add_kind;
	logic add_dirty;

	// Decoded port conditions
	assign add_xfer  = req_valid && !req_stall && (req_data.req_type == REQ_ADD);
	assign add_kind  = (rsp_data.result_kind == KIND_ACCEPTED)
		|| (rsp_data.result_kind == KIND_REJECTED);
	assign add_dirty = (rsp_data.fired_tag != '0) || rsp_data.was_removed;

	// Offered result holds while stalled
	`MTT_ASSERT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))

	// An add transfer is answered in the next cycle with a single closing result
	`MTT_ASSERT(a_add_answer, clk, arst_n, add_xfer |=> rsp_valid && rsp_data.last_of_run && add_kind)

	// Add results carry no tag and no removal mark
	`MTT_NEVER(a_add_fields, clk, arst_n, rsp_valid && add_kind && add_dirty)

	// While a run of firings is still open no new item is taken
	`MTT_NEVER(a_run_busy, clk, arst_n, rsp_valid && !rsp_data.last_of_run && !req_stall)

endmodule

bind multi_software_timer_table mtt_chk u_chk (.*);
